// ===== sv/lfk_pkg.sv =====
// Package: shared types, widths and constants of the leg forward kinematics block.
`timescale 1ns / 1ps
`default_nettype none
package lfk_pkg;
    localparam int ANGLE_WIDTH   = 16;
    localparam int COORD_WIDTH   = 16;
    localparam int OUT_WIDTH     = 24;
    localparam int CORDIC_STAGES = 16;
    localparam int CFG_WIDTH     = 3 * COORD_WIDTH;
    localparam int ZW            = 35;                      // Q30 angle accumulator
    localparam int XW            = 33;                      // Q30 CORDIC x and y
    localparam int TW            = 27;                      // Q24 cosine and sine
    localparam int VW            = OUT_WIDTH + 2;           // working coordinate width
    localparam int PW            = VW + TW;                 // one product
    localparam int SW            = PW + 1;                  // sum of two products
    localparam int ANGLE_SHIFT   = 33 - ANGLE_WIDTH;
    localparam int CORDIC_LAT    = CORDIC_STAGES + 2;
    localparam int ROT_LAT       = 2;
    localparam int TOTAL_LAT     = CORDIC_LAT + 3 * ROT_LAT + 1;

    localparam logic signed [ZW-1:0] Q30_HALF_PI = ZW'(64'sd1686629713);
    localparam logic signed [ZW-1:0] Q30_PI      = ZW'(64'sd3373259426);
    localparam logic signed [XW-1:0] Q30_GAIN    = XW'(64'sd652032874);

    typedef enum logic [2:0] {
        REG_LINK_BASE       = 3'd0,
        REG_LINK_THIGH_ROOT = 3'd1,
        REG_LINK_THIGH      = 3'd2,
        REG_LINK_SHANK      = 3'd3
    } t_reg_idx;

    typedef logic signed [TW-1:0] t_trig;
    typedef logic signed [VW-1:0] t_coord;

    typedef struct packed {
        logic [1:0]                    point_sel;
        logic signed [ANGLE_WIDTH-1:0] angle_roll;
        logic signed [ANGLE_WIDTH-1:0] angle_hip_pitch;
        logic signed [ANGLE_WIDTH-1:0] angle_knee_pitch;
    } t_in;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] pos_x;
        logic signed [OUT_WIDTH-1:0] pos_y;
        logic signed [OUT_WIDTH-1:0] pos_z;
    } t_out;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec;

    // Context carried alongside the vector through the rotation steps.
    typedef struct packed {
        logic [1:0] sel;
        t_trig      c0;
        t_trig      s0;
        t_trig      c1;
        t_trig      s1;
        t_trig      c2;
        t_trig      s2;
    } t_ctx;

    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = ZW'(843314857);
            1:  v = ZW'(497837829);
            2:  v = ZW'(263043837);
            3:  v = ZW'(133525159);
            4:  v = ZW'(67021687);
            5:  v = ZW'(33543516);
            6:  v = ZW'(16775851);
            7:  v = ZW'(8388437);
            8:  v = ZW'(4194283);
            9:  v = ZW'(2097149);
            default: v = (i < 30) ? (ZW'(1) <<< (30 - i)) : ((i == 30) ? ZW'(1) : ZW'(0));
        endcase
        return v;
    endfunction

    // Sign-extended coordinate of a packed link offset (axis 0 = x).
    function automatic t_coord link_coord(input logic [CFG_WIDTH-1:0] l, input int axis);
        logic signed [COORD_WIDTH-1:0] f;
        f = l[axis*COORD_WIDTH +: COORD_WIDTH];
        return VW'(f);
    endfunction

    function automatic t_vec link_vec(input logic [CFG_WIDTH-1:0] l);
        t_vec v;
        v.x = link_coord(l, 0);
        v.y = link_coord(l, 1);
        v.z = link_coord(l, 2);
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== sv/lfk_cordic.sv =====
// Pipelined CORDIC: cosine and sine of one joint angle in Q24.
`timescale 1ns / 1ps
`default_nettype none
module lfk_cordic
    import lfk_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic signed [ANGLE_WIDTH-1:0] i_angle,
    output logic                               o_valid,
    output t_trig                              o_cos,
    output t_trig                              o_sin
);
    logic signed [XW-1:0] r_x   [0:CORDIC_STAGES];
    logic signed [XW-1:0] r_y   [0:CORDIC_STAGES];
    logic signed [ZW-1:0] r_z   [0:CORDIC_STAGES];
    logic                 r_neg [0:CORDIC_STAGES];
    logic                 r_v   [0:CORDIC_STAGES];
    logic signed [ZW-1:0] n_z;
    logic                 n_neg;
    logic signed [XW-1:0] n_xr, n_yr;
    t_trig                r_cos, r_sin;
    logic                 r_vo;

    // Fold the angle into the half-turn around zero, negating the result later.
    always_comb begin
        n_z   = ZW'(i_angle) <<< ANGLE_SHIFT;
        n_neg = 1'b0;
        if (n_z > Q30_HALF_PI) begin
            n_z   = n_z - Q30_PI;
            n_neg = 1'b1;
        end else if (n_z < -Q30_HALF_PI) begin
            n_z   = n_z + Q30_PI;
            n_neg = 1'b1;
        end
        n_xr = (r_x[CORDIC_STAGES] + XW'(32)) >>> 6;
        n_yr = (r_y[CORDIC_STAGES] + XW'(32)) >>> 6;
    end

    always_ff @(posedge i_clk) begin
        r_x[0]   <= Q30_GAIN;
        r_y[0]   <= '0;
        r_z[0]   <= n_z;
        r_neg[0] <= n_neg;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (!r_z[i][ZW-1]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - atan_q30(i);
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + atan_q30(i);
            end
            r_neg[i+1] <= r_neg[i];
        end
        r_cos <= r_neg[CORDIC_STAGES] ? -TW'(n_xr) : TW'(n_xr);
        r_sin <= r_neg[CORDIC_STAGES] ? -TW'(n_yr) : TW'(n_yr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= CORDIC_STAGES; i++) begin
                r_v[i] <= 1'b0;
            end
            r_vo <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                r_v[i+1] <= r_v[i];
            end
            r_vo <= r_v[CORDIC_STAGES];
        end
    end

    assign o_valid = r_vo;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;
endmodule
`default_nettype wire

// ===== sv/lfk_rot.sv =====
// One rotation step of the transform chain: multiply, then round and add the link offset.
`timescale 1ns / 1ps
`default_nettype none
module lfk_rot
    import lfk_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [1:0]           i_step,
    input  wire logic                 i_roll,
    input  wire t_trig                i_c,
    input  wire t_trig                i_s,
    input  wire logic [CFG_WIDTH-1:0] i_link,
    input  wire t_vec                 i_vec,
    input  wire t_ctx                 i_ctx,
    output logic                      o_valid,
    output t_vec                      o_vec,
    output t_ctx                      o_ctx
);
    logic signed [PW-1:0] r_ac, r_bs, r_as, r_bc;
    t_vec                 r_vin, r_vec;
    t_ctx                 r_ctx1, r_ctx2;
    logic                 r_act;
    logic                 r_v1, r_v2;
    t_coord               n_a, n_b, n_p, n_q;
    logic signed [SW-1:0] n_sp, n_sq;
    t_vec                 n_vec, n_link;

    // Roll rotates (y, z); pitch rotates (x, z), with the sine sign handled by the caller.
    always_comb begin
        n_a = i_roll ? i_vec.y : i_vec.x;
        n_b = i_vec.z;
    end

    always_ff @(posedge i_clk) begin
        r_ac   <= PW'(n_a) * PW'(i_c);
        r_bs   <= PW'(n_b) * PW'(i_s);
        r_as   <= PW'(n_a) * PW'(i_s);
        r_bc   <= PW'(n_b) * PW'(i_c);
        r_vin  <= i_vec;
        r_ctx1 <= i_ctx;
        r_act  <= (i_step < i_ctx.sel);
    end

    always_comb begin
        n_link = link_vec(i_link);
        n_sp   = SW'(r_ac) - SW'(r_bs) + (SW'(1) <<< 23);
        n_sq   = SW'(r_as) + SW'(r_bc) + (SW'(1) <<< 23);
        n_p    = VW'(n_sp >>> 24);
        n_q    = VW'(n_sq >>> 24);
        n_vec  = r_vin;
        if (r_act) begin
            if (i_roll) begin
                n_vec.y = n_p;
            end else begin
                n_vec.x = n_p;
            end
            n_vec.z = n_q;
            n_vec.x = n_vec.x + n_link.x;
            n_vec.y = n_vec.y + n_link.y;
            n_vec.z = n_vec.z + n_link.z;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec  <= n_vec;
        r_ctx2 <= r_ctx1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_vec   = r_vec;
    assign o_ctx   = r_ctx2;
endmodule
`default_nettype wire

// ===== sv/leg_forward_kinematics_top.sv =====
// Top level of the leg forward kinematics block: configuration, trig units and transform chain.
`timescale 1ns / 1ps
`default_nettype none
// Each start transfer yields one o_valid strobe of its result.
// Throughput: one item per cycle; every unit is a straight pipeline, so o_busy stays low.
// The 16-stage CORDIC, the three rotation steps and the output register make up the pipeline.
// Synchronous active-low reset clears the link offsets to zero and empties the pipeline.
// Results are shown for one cycle only, as the receiver cannot stall.
module leg_forward_kinematics_top
    import lfk_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire t_in                  i_item,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_idx,
    input  wire logic [CFG_WIDTH-1:0] i_cfg_data,
    output logic                      o_valid,
    output t_out                      o_result
);
    // Link offset registers. The user must write them only while the pipeline is empty;
    // the block itself does not enforce this, and the stages read them directly.
    logic [CFG_WIDTH-1:0] r_link [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_link[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LINK_BASE:       r_link[0] <= i_cfg_data;
                REG_LINK_THIGH_ROOT: r_link[1] <= i_cfg_data;
                REG_LINK_THIGH:      r_link[2] <= i_cfg_data;
                REG_LINK_SHANK:      r_link[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic in_xfer;
    assign o_busy  = 1'b0;
    assign in_xfer = i_start && !o_busy;

    // Three trig units run side by side, one per joint.
    logic  tv0, tv1, tv2;
    t_trig c0, s0, c1, s1, c2, s2;

    lfk_cordic u_cordic_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_xfer),
        .i_angle(i_item.angle_roll), .o_valid(tv0), .o_cos(c0), .o_sin(s0));
    lfk_cordic u_cordic_hip (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_xfer),
        .i_angle(i_item.angle_hip_pitch), .o_valid(tv1), .o_cos(c1), .o_sin(s1));
    lfk_cordic u_cordic_knee (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_xfer),
        .i_angle(i_item.angle_knee_pitch), .o_valid(tv2), .o_cos(c2), .o_sin(s2));

    // The point selector travels beside the trig units.
    logic [1:0] r_sel [0:CORDIC_LAT-1];

    always_ff @(posedge i_clk) begin
        r_sel[0] <= i_item.point_sel;
        for (int i = 1; i < CORDIC_LAT; i++) begin
            r_sel[i] <= r_sel[i-1];
        end
    end

    // The chain starts from the selected link and applies the knee, hip and
    // roll steps in turn; a step beyond the selected point passes the vector on.
    t_ctx ctx0, ctx1, ctx2, ctx3;
    t_vec vec0, vec1, vec2, vec3;
    logic rv1, rv2, rv3;

    always_comb begin
        ctx0.sel = r_sel[CORDIC_LAT-1];
        ctx0.c0  = c0;
        ctx0.s0  = s0;
        ctx0.c1  = c1;
        ctx0.s1  = s1;
        ctx0.c2  = c2;
        ctx0.s2  = s2;
        vec0     = link_vec(r_link[ctx0.sel]);
    end

    // Pitch steps rotate by the negated sine, the roll step by the sine itself.
    lfk_rot u_rot_knee (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(tv2), .i_step(2'd2), .i_roll(1'b0),
        .i_c(ctx0.c2), .i_s(-ctx0.s2), .i_link(r_link[2]), .i_vec(vec0), .i_ctx(ctx0),
        .o_valid(rv1), .o_vec(vec1), .o_ctx(ctx1));
    lfk_rot u_rot_hip (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(rv1), .i_step(2'd1), .i_roll(1'b0),
        .i_c(ctx1.c1), .i_s(-ctx1.s1), .i_link(r_link[1]), .i_vec(vec1), .i_ctx(ctx1),
        .o_valid(rv2), .o_vec(vec2), .o_ctx(ctx2));
    lfk_rot u_rot_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(rv2), .i_step(2'd0), .i_roll(1'b1),
        .i_c(ctx2.c0), .i_s(ctx2.s0), .i_link(r_link[0]), .i_vec(vec2), .i_ctx(ctx2),
        .o_valid(rv3), .o_vec(vec3), .o_ctx(ctx3));

    // Output register with saturation to the result width.
    localparam t_coord SAT_HI = t_coord'((64'sd1 <<< (OUT_WIDTH - 1)) - 1);
    localparam t_coord SAT_LO = -SAT_HI - t_coord'(1);

    function automatic logic signed [OUT_WIDTH-1:0] sat(input t_coord v);
        t_coord t;
        t = v;
        if (t > SAT_HI) begin
            t = SAT_HI;
        end
        if (t < SAT_LO) begin
            t = SAT_LO;
        end
        return OUT_WIDTH'(t);
    endfunction

    t_out r_result;
    logic r_valid;

    always_ff @(posedge i_clk) begin
        r_result.pos_x <= sat(vec3.x);
        r_result.pos_y <= sat(vec3.y);
        r_result.pos_z <= sat(vec3.z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= rv3;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // The three trig units must stay in step with one another.
    a_trig_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tv0 == tv1) && (tv1 == tv2))
        else $error("trig units out of step");

    // The selected link context matches what rode beside the vector.
    a_ctx_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rv3 |-> (ctx3.sel == $past(ctx0.sel, 3 * ROT_LAT)))
        else $error("context lost in the rotation chain");

    // Every transfer always yields a result strobe at the full latency after it.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(in_xfer, TOTAL_LAT) && $past(i_rst_n, TOTAL_LAT) |-> o_valid)
        else $error("result strobe missing at the expected latency");
endmodule
`default_nettype wire

// ===== dv/tb_leg_forward_kinematics_top.sv =====
// Testbench of the leg forward kinematics top level: random and directed items checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
// The block turns three joint angles and a point selector into the position of that leg point.
// An initial block sets the link offsets, queues the items of each phase and then waits until
// every expected position has come out before it moves on to the next set of links.
// A driver process sends the queued items in bursts with random gaps between them.
// A monitor process predicts each accepted transfer with its own CORDIC and rotation chain.
// It also compares every strobed result, field by field, with the oldest prediction.
module tb_leg_forward_kinematics_top;
    import lfk_pkg::*;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam int     DRAIN_CYCLES = TOTAL_LAT + 10;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    t_in                  i_item;
    logic                 i_cfg_we;
    logic [2:0]           i_cfg_idx;
    logic [CFG_WIDTH-1:0] i_cfg_data;
    logic                 o_valid;
    t_out                 o_result;

    leg_forward_kinematics_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    // Items waiting to be sent, and positions waiting to come out.
    t_in  pending_items[$];
    t_out expected_pos[$];

    // The predictor's own copy of the four link offsets.
    logic [CFG_WIDTH-1:0] link_offset[4];

    int error_count;
    int sent_count;
    int result_count;
    int cfg_count;
    bit item_taken;
    int burst_left;
    int gap_left;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // Arithmetic right shifts of longint round towards minus infinity, as the block does.
    task automatic cordic_trig(input logic signed [ANGLE_WIDTH-1:0] ang,
                               output longint cos_q24, output longint sin_q24);
        longint z;
        longint x;
        longint y;
        longint nx;
        longint step_angle;
        bit     flip;
        z = longint'(ang) * (64'sd1 << ANGLE_SHIFT);
        x = GAIN_Q30;
        y = 0;
        flip = 1'b0;
        if (z > HALF_PI_Q30) begin
            z = z - PI_Q30;
            flip = 1'b1;
        end else if (z < -HALF_PI_Q30) begin
            z = z + PI_Q30;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            case (i)
                0: step_angle = 843314857;
                1: step_angle = 497837829;
                2: step_angle = 263043837;
                3: step_angle = 133525159;
                4: step_angle = 67021687;
                5: step_angle = 33543516;
                6: step_angle = 16775851;
                7: step_angle = 8388437;
                8: step_angle = 4194283;
                9: step_angle = 2097149;
                default: step_angle = (i < 31) ? (64'sd1 << (30 - i)) : 0;
            endcase
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - step_angle;
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + step_angle;
            end
            x = nx;
        end
        x = (x + 32) >>> 6;
        y = (y + 32) >>> 6;
        cos_q24 = flip ? -x : x;
        sin_q24 = flip ? -y : y;
    endtask

    function automatic longint offset_coord(input int link, input int axis);
        logic signed [COORD_WIDTH-1:0] f;
        f = link_offset[link][axis*COORD_WIDTH +: COORD_WIDTH];
        return longint'(f);
    endfunction

    function automatic longint rotate_q10(input longint a, input longint b,
                                          input longint ca, input longint cb);
        return (a * ca + b * cb + (64'sd1 << 23)) >>> 24;
    endfunction

    function automatic logic signed [OUT_WIDTH-1:0] clamp_out(input longint v);
        longint hi;
        hi = (64'sd1 << (OUT_WIDTH - 1)) - 1;
        if (v > hi) v = hi;
        if (v < -hi - 1) v = -hi - 1;
        return v[OUT_WIDTH-1:0];
    endfunction

    task automatic predict_point(input t_in it, output t_out pos);
        longint c[3];
        longint s[3];
        longint v[3];
        longint t0;
        longint t1;
        int     r;
        cordic_trig(it.angle_roll, c[0], s[0]);
        cordic_trig(it.angle_hip_pitch, c[1], s[1]);
        cordic_trig(it.angle_knee_pitch, c[2], s[2]);
        for (int k = 0; k < 3; k++) v[k] = offset_coord(it.point_sel, k);
        // Walk back from the selected point to the base, one joint per step.
        for (int j = it.point_sel; j >= 1; j--) begin
            r = j - 1;
            if (r == 0) begin
                t0 = rotate_q10(v[1], v[2], c[0], -s[0]);
                t1 = rotate_q10(v[1], v[2], s[0], c[0]);
                v[1] = t0;
                v[2] = t1;
            end else begin
                t0 = rotate_q10(v[0], v[2], c[r], s[r]);
                t1 = rotate_q10(v[0], v[2], -s[r], c[r]);
                v[0] = t0;
                v[2] = t1;
            end
            for (int k = 0; k < 3; k++) v[k] = v[k] + offset_coord(r, k);
        end
        pos.pos_x = clamp_out(v[0]);
        pos.pos_y = clamp_out(v[1]);
        pos.pos_z = clamp_out(v[2]);
    endtask

    // Angles are spread over the whole range, the quadrant fold at plus and minus half pi,
    // small values and the two extremes.
    function automatic logic signed [ANGLE_WIDTH-1:0] pick_angle();
        case ($urandom_range(0, 3))
            0: return ANGLE_WIDTH'($urandom);
            1: return ($urandom_range(0, 1) ? 16'sd12868 : -16'sd12868)
                      + 16'($signed($urandom_range(0, 8)) - 4);
            2: return 16'($signed($urandom_range(0, 512)) - 256);
            default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    function automatic logic [CFG_WIDTH-1:0] pick_offset(input int style);
        logic [CFG_WIDTH-1:0] d;
        case (style)
            0: d = '0;
            1: d = '1;
            2: d = {3{16'h7fff}};
            3: d = {3{16'h8000}};
            4: d = CFG_WIDTH'({$urandom, $urandom});
            default: d = {16'($signed($urandom_range(0, 2048)) - 1024),
                          16'($signed($urandom_range(0, 2048)) - 1024),
                          16'($signed($urandom_range(0, 2048)) - 1024)};
        endcase
        return d;
    endfunction

    // Register writes are issued only while nothing is in flight.
    task automatic write_link(input t_reg_idx idx, input logic [CFG_WIDTH-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        link_offset[idx] = data;
        cfg_count++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // An index beyond the four links must leave every offset untouched.
    task automatic write_unknown_index();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = 3'($urandom_range(4, 7));
        i_cfg_data = CFG_WIDTH'({$urandom, $urandom});
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_pos.size() != 0 || i_start)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Driver: inputs change on the falling edge and an item is held until it is taken.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !item_taken) begin
                // The current transfer has not happened yet, so the item stays put.
            end else if (gap_left > 0) begin
                gap_left--;
                i_start = 1'b0;
            end else if (pending_items.size() != 0) begin
                i_item  = pending_items.pop_front();
                i_start = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_start = 1'b0;
            end
        end
    end

    // Monitor: inputs and outputs are sampled on the rising edge.
    always @(posedge i_clk) begin
        t_out pred;
        t_out want;
        item_taken = 1'b0;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                predict_point(i_item, pred);
                expected_pos.push_back(pred);
                item_taken = 1'b1;
                sent_count++;
            end
            if (o_valid) begin
                result_count++;
                if (expected_pos.size() == 0) begin
                    error_count++;
                    $display("%0t: result with no item outstanding: x=%0d y=%0d z=%0d",
                             $time, o_result.pos_x, o_result.pos_y, o_result.pos_z);
                end else begin
                    want = expected_pos.pop_front();
                    if (o_result.pos_x !== want.pos_x) begin
                        error_count++;
                        $display("%0t: pos_x expected %0d actual %0d",
                                 $time, want.pos_x, o_result.pos_x);
                    end
                    if (o_result.pos_y !== want.pos_y) begin
                        error_count++;
                        $display("%0t: pos_y expected %0d actual %0d",
                                 $time, want.pos_y, o_result.pos_y);
                    end
                    if (o_result.pos_z !== want.pos_z) begin
                        error_count++;
                        $display("%0t: pos_z expected %0d actual %0d",
                                 $time, want.pos_z, o_result.pos_z);
                    end
                end
            end
        end
    end

    initial begin
        t_in it;
        logic signed [ANGLE_WIDTH-1:0] corner[8];
        corner = '{16'sd0, 16'sh7fff, 16'sh8000, 16'sd12868, 16'sd12869,
                   -16'sd12868, -16'sd12869, 16'sd6434};
        error_count  = 0;
        sent_count   = 0;
        result_count = 0;
        cfg_count    = 0;
        item_taken   = 1'b0;
        burst_left   = 0;
        gap_left     = 0;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_item       = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_LINK_BASE;
        i_cfg_data   = '0;
        for (int l = 0; l < 4; l++) link_offset[l] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: every point at fixed angles with the offsets at reset, then at the corner angles.
        for (int p = 0; p < 4; p++) begin
            it.point_sel        = 2'(p);
            it.angle_roll       = 16'sd3000;
            it.angle_hip_pitch  = -16'sd5000;
            it.angle_knee_pitch = 16'sd7000;
            pending_items.push_back(it);
        end
        wait_drained();
        write_link(REG_LINK_BASE, pick_offset(5));
        write_link(REG_LINK_THIGH_ROOT, pick_offset(5));
        write_link(REG_LINK_THIGH, pick_offset(5));
        write_link(REG_LINK_SHANK, pick_offset(5));
        write_unknown_index();
        for (int k = 0; k < 16; k++) begin
            it.point_sel        = 2'(k % 4);
            it.angle_roll       = corner[k % 8];
            it.angle_hip_pitch  = corner[(k + 3) % 8];
            it.angle_knee_pitch = corner[(k + 5) % 8];
            pending_items.push_back(it);
        end
        wait_drained();

        // Random phases, each with its own offsets; the extremes come first.
        for (int ph = 0; ph < 6; ph++) begin
            write_link(REG_LINK_BASE, pick_offset(ph < 4 ? ph : 4 + $urandom_range(0, 1)));
            write_link(REG_LINK_THIGH_ROOT, pick_offset(ph < 4 ? ph : $urandom_range(4, 5)));
            write_link(REG_LINK_THIGH, pick_offset(ph < 4 ? ph : $urandom_range(4, 5)));
            write_link(REG_LINK_SHANK, pick_offset(ph < 4 ? ph : $urandom_range(4, 5)));
            if (ph % 2 == 1) write_unknown_index();
            for (int n = 0; n < 280; n++) begin
                it.point_sel        = 2'($urandom_range(0, 3));
                it.angle_roll       = pick_angle();
                it.angle_hip_pitch  = pick_angle();
                it.angle_knee_pitch = pick_angle();
                pending_items.push_back(it);
            end
            // The sender holds off here until every outstanding position has arrived.
            wait_drained();
        end

        $display("Covered %0d items and %0d results over %0d link offset writes,",
                 sent_count, result_count, cfg_count);
        $display("with all four points, folded and extreme angles and extreme offsets.");
        if (error_count == 0 && expected_pos.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
sv/lfk_pkg.sv
sv/lfk_cordic.sv
sv/lfk_rot.sv
sv/leg_forward_kinematics_top.sv
dv/tb_leg_forward_kinematics_top.sv
